@@ src/qat_pkg.sv @@
package qat_pkg;

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [1:0] QK_NONE   = 2'd0;
  localparam logic [1:0] QK_DQUOTE = 2'd1;
  localparam logic [1:0] QK_SQUOTE = 2'd2;
  localparam logic [1:0] QK_BRACK  = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       line_end;
  } res_item_t;

endpackage

@@ src/qat_in_reg.sv @@
module qat_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  qat_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              hold_valid,
  output qat_pkg::in_item_t hold_item
);

  logic              valid_r, valid_nxt;
  qat_pkg::in_item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign hold_valid = valid_r;
  assign hold_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ src/qat_core.sv @@
module qat_core (
  input  logic               clk,
  input  logic               rst_n,
  input  qat_pkg::in_item_t  item,
  input  logic               advance,
  output logic               has_res,
  output qat_pkg::res_item_t res
);

  logic       inside_r, inside_nxt;
  logic [1:0] qk_r, qk_nxt;
  logic       pb_r, pb_nxt;
  logic       re_r, re_nxt;

  always_comb begin
    logic [7:0] c;
    logic       blank;
    logic       special;
    logic       take;
    logic       closes;
    logic       shielded;
    c        = item.in_byte;
    blank    = (c == qat_pkg::CH_SPACE) || (c == qat_pkg::CH_TAB);
    special  = blank || (c == qat_pkg::CH_DQUOTE) || (c == qat_pkg::CH_SQUOTE) ||
               (c == qat_pkg::CH_LBRACK) || (c == qat_pkg::CH_RBRACK);
    inside_nxt = inside_r;
    qk_nxt     = qk_r;
    pb_nxt     = pb_r;
    re_nxt     = re_r;
    take       = 1'b0;
    res        = '0;

    if (!inside_r) begin
      if (!blank) begin
        inside_nxt = 1'b1;
        pb_nxt     = 1'b0;
        re_nxt     = 1'b0;
        if (c == qat_pkg::CH_DQUOTE) begin
          qk_nxt = qat_pkg::QK_DQUOTE;
        end else if (c == qat_pkg::CH_SQUOTE) begin
          qk_nxt = qat_pkg::QK_SQUOTE;
        end else if (c == qat_pkg::CH_LBRACK) begin
          qk_nxt = qat_pkg::QK_BRACK;
        end else begin
          qk_nxt = qat_pkg::QK_NONE;
          take   = 1'b1;
        end
      end
    end else begin
      take = 1'b1;
    end

    unique case (qk_nxt)
      qat_pkg::QK_NONE:   closes = blank;
      qat_pkg::QK_DQUOTE: closes = (c == qat_pkg::CH_DQUOTE);
      qat_pkg::QK_SQUOTE: closes = (c == qat_pkg::CH_SQUOTE);
      qat_pkg::QK_BRACK:  closes = (c == qat_pkg::CH_RBRACK);
      default:            closes = 1'b0;
    endcase

    // backslash flags are only meaningful once the token is open
    shielded = pb_nxt && special;

    if (take) begin
      if (!shielded && closes) begin
        res.token_end = 1'b1;
        inside_nxt    = 1'b0;
        qk_nxt        = qat_pkg::QK_NONE;
        pb_nxt        = 1'b0;
        re_nxt        = 1'b0;
      end else begin
        if (re_nxt || (c != qat_pkg::CH_BSLASH)) begin
          res.out_byte   = c;
          res.byte_valid = 1'b1;
          re_nxt         = 1'b0;
        end else begin
          re_nxt = 1'b1;
        end
        pb_nxt = (c == qat_pkg::CH_BSLASH);
      end
    end

    if (item.line_last) begin
      if (inside_nxt) begin
        res.token_end = 1'b1;
      end
      res.line_end = 1'b1;
      inside_nxt   = 1'b0;
      qk_nxt       = qat_pkg::QK_NONE;
      pb_nxt       = 1'b0;
      re_nxt       = 1'b0;
    end

    has_res = res.byte_valid || res.token_end || res.line_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      qk_r     <= qat_pkg::QK_NONE;
      pb_r     <= 1'b0;
      re_r     <= 1'b0;
    end else if (advance) begin
      inside_r <= inside_nxt;
      qk_r     <= qk_nxt;
      pb_r     <= pb_nxt;
      re_r     <= re_nxt;
    end
  end

endmodule

@@ src/qat_out_reg.sv @@
module qat_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  qat_pkg::res_item_t res,
  input  logic               out_tready,
  output logic               out_tvalid,
  output qat_pkg::res_item_t out_item
);

  logic               valid_r, valid_nxt;
  qat_pkg::res_item_t item_r;

  assign out_tvalid = valid_r;
  assign out_item   = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= res;
    end
  end

endmodule

@@ src/quoted_argument_tokenizer_top.sv @@
// Shell-style tokenizer for log lines: one byte per request in, at most one
// result per byte out (token byte and/or token end / line end flags). Takes
// one byte per cycle with back-to-back requests while the output is not
// stalled; a byte passes the input register, then the result register, before
// its result is on the outputs. The tokenizer state is updated when a byte
// leaves the input register. Bytes that give no result (blanks between
// tokens, opening quotes) are absorbed without occupying the output.
module quoted_argument_tokenizer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // line_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] token_end
  output logic       out_tlast   // line_end
);

  qat_pkg::in_item_t  in_item;
  qat_pkg::in_item_t  hold_item;
  qat_pkg::res_item_t res;
  qat_pkg::res_item_t out_item;
  logic               hold_valid;
  logic               has_res;
  logic               advance;

  assign in_item.in_byte   = in_tdata;
  assign in_item.line_last = in_tlast;

  // a byte moves on when its result has room, or when it gives none
  assign advance = hold_valid && (!has_res || !out_tvalid || out_tready);

  qat_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  qat_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (hold_item),
    .advance (advance),
    .has_res (has_res),
    .res     (res)
  );

  qat_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && has_res),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_item   (out_item)
  );

  assign out_tdata    = out_item.out_byte;
  assign out_tuser[0] = out_item.byte_valid;
  assign out_tuser[1] = out_item.token_end;
  assign out_tlast    = out_item.line_end;

endmodule

@@ sim/quoted_argument_tokenizer_top_tb.sv @@
module quoted_argument_tokenizer_top_tb;

  localparam int RND_ITEMS   = 1350;
  localparam int PHASE_LEN   = 350;
  localparam int HOLD_AT     = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int DIR_ROWS    = 24;

  typedef struct packed {
    logic [7:0]         ch;
    logic               last;
    logic               pinned;
    qat_pkg::res_item_t res;
  } dir_row_t;

  localparam qat_pkg::res_item_t NO_PIN = '0;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic [1:0] out_tuser;
  logic       out_tlast;

  // tokenizer state as predicted
  logic       tk_inside = 1'b0;
  logic [1:0] tk_quote  = qat_pkg::QK_NONE;
  logic       tk_bslash = 1'b0;
  logic       tk_kept   = 1'b0;

  qat_pkg::res_item_t tok_due[$];
  qat_pkg::res_item_t pin_res  = NO_PIN;
  logic       pin_en   = 1'b0;
  int         errors   = 0;
  int         idle_cyc = 0;
  int         rnd_sent = 0;
  int         snd_idle = 0;
  int         rcv_stall = 0;
  int         hold_cnt = 0;
  bit         held     = 1'b0;
  logic [7:0] line_q[$];

  // directed rows: extremes, escapes, every quote kind, line-end cases
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{"a",                1'b1, 1'b1, '{"a",   1'b1, 1'b1, 1'b1}},  // one-byte line
    '{qat_pkg::CH_SPACE,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b1}},  // blank-only line
    '{qat_pkg::CH_DQUOTE, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}},  // empty quoted token
    '{8'h00,              1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},  // zero byte is text
    '{8'hFF,              1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
    '{qat_pkg::CH_TAB,    1'b0, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b0}},
    '{qat_pkg::CH_LBRACK, 1'b0, 1'b0, NO_PIN},
    '{"x",                1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_BSLASH, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_RBRACK, 1'b0, 1'b0, NO_PIN},  // escaped close bracket
    '{qat_pkg::CH_RBRACK, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_SQUOTE, 1'b0, 1'b0, NO_PIN},  // adjacent token
    '{qat_pkg::CH_BSLASH, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_BSLASH, 1'b0, 1'b0, NO_PIN},  // doubled: second kept, still shields
    '{qat_pkg::CH_SQUOTE, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_SQUOTE, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_DQUOTE, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_SPACE,  1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_BSLASH, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_DQUOTE, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_TAB,    1'b1, 1'b0, NO_PIN},  // unclosed at line end
    '{qat_pkg::CH_BSLASH, 1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_SPACE,  1'b0, 1'b0, NO_PIN},
    '{qat_pkg::CH_SPACE,  1'b1, 1'b1, '{8'h00, 1'b0, 1'b1, 1'b1}}
  };

  quoted_argument_tokenizer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [7:0] in_byte
    .in_tlast   (in_tlast),   // line_last
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [7:0] out_byte
    .out_tuser  (out_tuser),  // [0] byte_valid, [1] token_end
    .out_tlast  (out_tlast)   // line_end
  );

  function automatic logic is_blank(input logic [7:0] c);
    return c == qat_pkg::CH_SPACE || c == qat_pkg::CH_TAB;
  endfunction

  function automatic logic is_special(input logic [7:0] c);
    return is_blank(c) || c == qat_pkg::CH_DQUOTE || c == qat_pkg::CH_SQUOTE ||
           c == qat_pkg::CH_LBRACK || c == qat_pkg::CH_RBRACK;
  endfunction

  function automatic bit tokenize_byte(input logic [7:0] c, input logic last,
                                       output qat_pkg::res_item_t r);
    logic take;
    logic shielded;
    logic closes;
    take = 1'b0;
    r    = '0;
    if (!tk_inside) begin
      if (!is_blank(c)) begin
        tk_inside = 1'b1;
        tk_bslash = 1'b0;
        tk_kept   = 1'b0;
        case (c)
          qat_pkg::CH_DQUOTE: tk_quote = qat_pkg::QK_DQUOTE;
          qat_pkg::CH_SQUOTE: tk_quote = qat_pkg::QK_SQUOTE;
          qat_pkg::CH_LBRACK: tk_quote = qat_pkg::QK_BRACK;
          default: begin
            tk_quote = qat_pkg::QK_NONE;
            take     = 1'b1;
          end
        endcase
      end
    end else begin
      take = 1'b1;
    end
    if (take) begin
      shielded = tk_bslash && is_special(c);
      case (tk_quote)
        qat_pkg::QK_NONE:   closes = is_blank(c);
        qat_pkg::QK_DQUOTE: closes = (c == qat_pkg::CH_DQUOTE);
        qat_pkg::QK_SQUOTE: closes = (c == qat_pkg::CH_SQUOTE);
        default:            closes = (c == qat_pkg::CH_RBRACK);
      endcase
      if (!shielded && closes) begin
        r.token_end = 1'b1;
        tk_inside   = 1'b0;
        tk_quote    = qat_pkg::QK_NONE;
        tk_bslash   = 1'b0;
        tk_kept     = 1'b0;
      end else begin
        // a backslash is dropped unless the one before it was dropped
        if (tk_kept || c != qat_pkg::CH_BSLASH) begin
          r.out_byte   = c;
          r.byte_valid = 1'b1;
          tk_kept      = 1'b0;
        end else begin
          tk_kept = 1'b1;
        end
        tk_bslash = (c == qat_pkg::CH_BSLASH);
      end
    end
    if (last) begin
      if (tk_inside) r.token_end = 1'b1;
      r.line_end = 1'b1;
      tk_inside  = 1'b0;
      tk_quote   = qat_pkg::QK_NONE;
      tk_bslash  = 1'b0;
      tk_kept    = 1'b0;
    end
    return r.byte_valid || r.token_end || r.line_end;
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return qat_pkg::CH_SPACE;
      1: return qat_pkg::CH_TAB;
      2: begin
        case ($urandom_range(0, 3))
          0: return qat_pkg::CH_DQUOTE;
          1: return qat_pkg::CH_SQUOTE;
          2: return qat_pkg::CH_LBRACK;
          default: return qat_pkg::CH_RBRACK;
        endcase
      end
      3: return qat_pkg::CH_BSLASH;
      4, 5, 6: return 8'($urandom_range(8'h61, 8'h7A));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // pin fields are read at the accepting edge, so they change with the data
  task automatic send_req(input logic [7:0] b, input logic last,
                          input logic pe, input qat_pkg::res_item_t pr);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    pin_en    = pe;
    pin_res   = pr;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  // receiver: random stalls, plus one long hold-off to back the block up
  initial begin
    forever begin
      @(negedge clk);
      if (!held && rnd_sent >= HOLD_AT) begin
        held     = 1'b1;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        out_tready = 1'b0;
        hold_cnt--;
      end else begin
        out_tready = ($urandom_range(0, 99) >= rcv_stall);
      end
    end
  end

  always @(posedge clk) begin
    qat_pkg::res_item_t r;
    qat_pkg::res_item_t got;
    bit        has;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        has = tokenize_byte(in_tdata, in_tlast, r);
        if (pin_en) begin
          r   = pin_res;
          has = 1'b1;
        end
        if (has) tok_due.push_back(r);
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata, out_tuser[0], out_tuser[1], out_tlast};
        if (tok_due.size() == 0) begin
          $error("result with nothing expected: %p", got);
          errors++;
        end else begin
          r = tok_due.pop_front();
          if (r.byte_valid && got.out_byte !== r.out_byte) begin
            $error("out_byte: expected %h, got %h", r.out_byte, got.out_byte);
            errors++;
          end
          if (got.byte_valid !== r.byte_valid) begin
            $error("byte_valid: expected %b, got %b", r.byte_valid, got.byte_valid);
            errors++;
          end
          if (got.token_end !== r.token_end) begin
            $error("token_end: expected %b, got %b", r.token_end, got.token_end);
            errors++;
          end
          if (got.line_end !== r.line_end) begin
            $error("line_end: expected %b, got %b", r.line_end, got.line_end);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc = 0;
      else idle_cyc++;
    end
  end

  initial begin
    wait (idle_cyc >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int phase;
    int kind;
    logic [7:0] closer;
    @(posedge rst_n);

    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].pinned, dir_tab[i].res);
    end

    while (rnd_sent < RND_ITEMS) begin
      phase = (rnd_sent / PHASE_LEN) % 4;
      case (phase)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 73; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 73; end
        default: begin snd_idle = 27; rcv_stall = 27; end
      endcase
      line_q.delete();
      if ($urandom_range(0, 4) != 0) begin
        repeat ($urandom_range(1, 5)) begin
          repeat ($urandom_range(0, 2))
            line_q.push_back($urandom_range(0, 1) ? qat_pkg::CH_SPACE : qat_pkg::CH_TAB);
          kind = $urandom_range(0, 3);
          case (kind)
            1: begin line_q.push_back(qat_pkg::CH_DQUOTE); closer = qat_pkg::CH_DQUOTE; end
            2: begin line_q.push_back(qat_pkg::CH_SQUOTE); closer = qat_pkg::CH_SQUOTE; end
            3: begin line_q.push_back(qat_pkg::CH_LBRACK); closer = qat_pkg::CH_RBRACK; end
            default: closer = qat_pkg::CH_SPACE;
          endcase
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) line_q.push_back(qat_pkg::CH_BSLASH);
            line_q.push_back(pick_char());
          end
          if ($urandom_range(0, 9) != 0) line_q.push_back(closer);
        end
      end else begin
        repeat ($urandom_range(1, 12)) line_q.push_back(pick_char());
      end
      if (line_q.size() == 0) line_q.push_back(pick_char());
      foreach (line_q[i]) begin
        send_req(line_q[i], i == line_q.size() - 1, 1'b0, NO_PIN);
        rnd_sent++;
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    while (tok_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0 && tok_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
